// ===== src/lpfw_pkg.sv =====
// Shared types and constants for the LED pixel fan-out writer.
package lpfw_pkg;

  // Pixel addressing and map geometry
  localparam int GRID_COLS    = 11;
  localparam int CORNER_START = 110;
  localparam int ALARM_INDEX  = 114;
  localparam int MAP_DEPTH    = 128;
  localparam int ADDR_W       = $clog2(MAP_DEPTH);
  localparam int IDX_W        = 8;
  localparam int RANGE_W      = IDX_W + 1;

  // Run length limits
  localparam int MAX_RUN = 8;
  localparam int CNT_W   = 4;
  localparam int POS_W   = $clog2(MAX_RUN);

  // Field widths
  localparam int PIX_W   = 7;
  localparam int GRID_W  = 4;
  localparam int BASE_W  = 8;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 4 * CHAN_W;
  localparam int LED_W   = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_CNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_CNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_MODE = 2'd3;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QLVL_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [CNT_W-1:0]   cnt;
    logic [COLOR_W-1:0] color;
  } lpfw_job_t;

endpackage

// ===== src/lpfw_front.sv =====
// Front end: configuration registers, pixel classification, map memory, job issue.
module lpfw_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpfw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpfw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic                           in_use_grid,
  input  logic [lpfw_pkg::PIX_W-1:0]      in_pixel_index,
  input  logic [lpfw_pkg::GRID_W-1:0]     in_grid_col,
  input  logic [lpfw_pkg::GRID_W-1:0]     in_grid_row,
  input  logic [lpfw_pkg::BASE_W-1:0]     in_map_base,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_red_in,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_blue_in,
  input  logic [lpfw_pkg::QLVL_W-1:0]     q_level,
  output logic                           q_push,
  output lpfw_pkg::lpfw_job_t            q_job
);
  import lpfw_pkg::*;

  logic [CNT_W-1:0] letter_cnt_r, corner_cnt_r, alarm_cnt_r;
  logic             white_mode_r;

  logic [BASE_W-1:0] map_mem [MAP_DEPTH];
  logic [BASE_W-1:0] rd_data_r;

  logic               s1_v_r;
  logic [CNT_W-1:0]   s1_cnt_r;
  logic [COLOR_W-1:0] s1_color_r;

  logic               accept;
  logic [IDX_W-1:0]   idx;
  logic               in_range;
  logic [ADDR_W-1:0]  addr;
  logic [CNT_W-1:0]   grp_cnt;
  logic [CNT_W-1:0]   run_cnt;
  logic [CHAN_W-1:0]  min_rg, min_rgb, white;
  logic [COLOR_W-1:0] color;
  logic               map_we;
  logic               issue;
  logic [QLVL_W:0]    pending;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_cnt_r <= CNT_W'(1);
      corner_cnt_r <= CNT_W'(1);
      alarm_cnt_r  <= CNT_W'(1);
      white_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LETTER_CNT: letter_cnt_r <= cfg_data[CNT_W-1:0];
        CFG_CORNER_CNT: corner_cnt_r <= cfg_data[CNT_W-1:0];
        CFG_ALARM_CNT:  alarm_cnt_r  <= cfg_data[CNT_W-1:0];
        CFG_WHITE_MODE: white_mode_r <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // reserve queue room for the job in flight
  assign pending = (QLVL_W+1)'(q_level) + (QLVL_W+1)'(s1_v_r);
  assign in_full = (pending >= (QLVL_W+1)'(QDEPTH));
  assign accept  = in_push && !in_full;

  always_comb begin
    if (in_use_grid)
      idx = IDX_W'(in_grid_col) + IDX_W'(in_grid_row) * IDX_W'(GRID_COLS);
    else
      idx = IDX_W'(in_pixel_index);
  end

  assign in_range = (RANGE_W'(idx) < RANGE_W'(MAP_DEPTH));
  assign addr     = idx[ADDR_W-1:0];

  always_comb begin
    priority if (RANGE_W'(idx) < RANGE_W'(CORNER_START)) grp_cnt = letter_cnt_r;
    else if (RANGE_W'(idx) < RANGE_W'(ALARM_INDEX))      grp_cnt = corner_cnt_r;
    else                                                 grp_cnt = alarm_cnt_r;
  end

  // saturate long runs
  assign run_cnt = (grp_cnt > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : grp_cnt;

  assign min_rg  = (in_red_in < in_green_in) ? in_red_in : in_green_in;
  assign min_rgb = (min_rg < in_blue_in) ? min_rg : in_blue_in;
  assign white   = white_mode_r ? min_rgb : '0;
  assign color   = {white, in_red_in - white, in_green_in - white, in_blue_in - white};

  assign map_we = accept && in_range && (in_req_type == REQ_LOAD);
  // a zero-length run is dropped here
  assign issue  = accept && in_range && (in_req_type == REQ_WRITE) && (run_cnt != '0);

  always_ff @(posedge clk) begin
    if (map_we)
      map_mem[addr] <= in_map_base;
    rd_data_r <= map_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_v_r <= 1'b0;
    else
      s1_v_r <= issue;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_cnt_r   <= run_cnt;
      s1_color_r <= color;
    end
  end

  assign q_push      = s1_v_r;
  assign q_job.base  = rd_data_r;
  assign q_job.cnt   = s1_cnt_r;
  assign q_job.color = s1_color_r;

endmodule

// ===== src/lpfw_queue.sv =====
// Short job queue between the front end and the write sequencer.
module lpfw_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  lpfw_pkg::lpfw_job_t         push_job,
  input  logic                        pop,
  output lpfw_pkg::lpfw_job_t         head_job,
  output logic [lpfw_pkg::QLVL_W-1:0] level
);
  import lpfw_pkg::*;

  lpfw_job_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop)
      level_nxt = level_r + QLVL_W'(1);
    else if (pop && !push)
      level_nxt = level_r - QLVL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr_r] <= push_job;
  end

  assign head_job = slots[rd_ptr_r];
  assign level    = level_r;

endmodule

// ===== src/lpfw_back.sv =====
// Write sequencer: expands one job into consecutive strip writes.
module lpfw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpfw_pkg::lpfw_job_t          head_job,
  input  logic [lpfw_pkg::QLVL_W-1:0]  q_level,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [lpfw_pkg::LED_W-1:0]   out_led_index,
  output logic [lpfw_pkg::COLOR_W-1:0] out_packed_color,
  output logic                         out_last_write
);
  import lpfw_pkg::*;

  logic               active_r;
  logic [BASE_W-1:0]  base_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [COLOR_W-1:0] color_r;
  logic [POS_W-1:0]   run_cnt_r;
  logic               last;
  logic               xfer;

  assign last  = ((CNT_W'(run_cnt_r) + CNT_W'(1)) == cnt_r);
  assign xfer  = active_r && out_pop;
  // load the next job when idle or as the final write transfers
  assign q_pop = (q_level != '0) && (!active_r || (xfer && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      run_cnt_r <= '0;
    end else if (q_pop) begin
      active_r  <= 1'b1;
      run_cnt_r <= '0;
    end else if (xfer) begin
      if (last) begin
        active_r  <= 1'b0;
        run_cnt_r <= '0;
      end else begin
        run_cnt_r <= run_cnt_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      base_r  <= head_job.base;
      cnt_r   <= head_job.cnt;
      color_r <= head_job.color;
    end
  end

  assign out_empty        = !active_r;
  assign out_led_index    = LED_W'(base_r) + LED_W'(run_cnt_r);
  assign out_packed_color = color_r;
  assign out_last_write   = last;

endmodule

// ===== src/led_pixel_fanout_writer_top.sv =====
// Top level of the LED pixel fan-out writer.
//
//   channel  direction  handshake          transfer when
//   in_*     input      in_push / in_full   in_push && !in_full
//   out_*    output     out_empty / out_pop out_pop && !out_empty
//   cfg_*    input      cfg_we              cfg_we
//
// A write request enters the job queue in the cycle after its transfer (map read and
// issue register share one stage); with the sequencer idle its first strip write is
// offered once the job has passed the issue register, the queue and the sequencer's
// job registers. A load updates the map at its transfer. The sequencer emits one
// strip write per cycle while out_pop is held; queued jobs run back to back.
// Synchronous active-low reset clears control state; the map is not cleared.
// in_full rises when the queued jobs plus the job in flight reach four.
module led_pixel_fanout_writer_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpfw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpfw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_req_type,
  input  logic                           in_use_grid,
  input  logic [lpfw_pkg::PIX_W-1:0]      in_pixel_index,
  input  logic [lpfw_pkg::GRID_W-1:0]     in_grid_col,
  input  logic [lpfw_pkg::GRID_W-1:0]     in_grid_row,
  input  logic [lpfw_pkg::BASE_W-1:0]     in_map_base,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_red_in,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [lpfw_pkg::CHAN_W-1:0]     in_blue_in,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [lpfw_pkg::LED_W-1:0]      out_led_index,
  output logic [lpfw_pkg::COLOR_W-1:0]    out_packed_color,
  output logic                           out_last_write
);
  import lpfw_pkg::*;

  logic              q_push, q_pop;
  lpfw_job_t         q_push_job, q_head_job;
  logic [QLVL_W-1:0] q_level;

  lpfw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_use_grid    (in_use_grid),
    .in_pixel_index (in_pixel_index),
    .in_grid_col    (in_grid_col),
    .in_grid_row    (in_grid_row),
    .in_map_base    (in_map_base),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .q_level        (q_level),
    .q_push         (q_push),
    .q_job          (q_push_job)
  );

  lpfw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .level    (q_level)
  );

  lpfw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_job         (q_head_job),
    .q_level          (q_level),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_led_index    (out_led_index),
    .out_packed_color (out_packed_color),
    .out_last_write   (out_last_write)
  );

endmodule

// ===== bench/led_pixel_fanout_writer_top_tb.sv =====
// Self-checking testbench for the LED pixel fan-out writer: map loads, pixel writes, runs.
`timescale 1ns / 100ps

module led_pixel_fanout_writer_top_tb;
  import lpfw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int PHASE_ITEMS    = 26;
  localparam int RAND_PHASES    = 6;

  typedef struct {
    logic               req_type;
    logic               use_grid;
    logic [PIX_W-1:0]   pixel_index;
    logic [GRID_W-1:0]  grid_col;
    logic [GRID_W-1:0]  grid_row;
    logic [BASE_W-1:0]  map_base;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
  } pixel_req_t;

  typedef struct {
    logic [LED_W-1:0]   led_index;
    logic [COLOR_W-1:0] packed_color;
    logic               last_write;
  } strip_write_t;

  // Predicts strip writes from accepted pixel requests and checks them in order.
  class strip_scoreboard;
    logic [BASE_W-1:0] base_map [MAP_DEPTH];
    bit                loaded [MAP_DEPTH];
    logic [3:0]        letter_cnt = 4'd1;
    logic [3:0]        corner_cnt = 4'd1;
    logic [3:0]        alarm_cnt  = 4'd1;
    logic              white_mode = 1'b0;
    strip_write_t      pending [$];
    int                requests = 0;
    int                loads = 0;
    int                writes_seen = 0;
    int                errors = 0;

    static function int slot_of(pixel_req_t r);
      return r.use_grid ? int'(r.grid_col) + int'(r.grid_row) * GRID_COLS
                        : int'(r.pixel_index);
    endfunction

    function void set_regs(logic [3:0] l, logic [3:0] c, logic [3:0] a, logic w);
      letter_cnt = l;
      corner_cnt = c;
      alarm_cnt  = a;
      white_mode = w;
    endfunction

    function void note_request(pixel_req_t r);
      int           slot;
      int           n;
      logic [7:0]   w, rr, gg, bb;
      strip_write_t s;
      requests++;
      slot = slot_of(r);
      // beyond the map: no writes, loads ignored
      if (slot >= MAP_DEPTH) return;
      if (r.req_type == REQ_LOAD) begin
        loads++;
        base_map[slot] = r.map_base;
        loaded[slot] = 1'b1;
        return;
      end
      if (slot < CORNER_START) n = letter_cnt;
      else if (slot < ALARM_INDEX) n = corner_cnt;
      else n = alarm_cnt;
      if (n > MAX_RUN) n = MAX_RUN;
      rr = r.red;
      gg = r.green;
      bb = r.blue;
      w = 8'h00;
      if (white_mode) begin
        w = rr;
        if (gg < w) w = gg;
        if (bb < w) w = bb;
        rr = rr - w;
        gg = gg - w;
        bb = bb - w;
      end
      for (int i = 0; i < n; i++) begin
        s.led_index    = LED_W'(int'(base_map[slot]) + i);
        s.packed_color = {w, rr, gg, bb};
        s.last_write   = (i + 1 == n);
        pending.push_back(s);
      end
    endfunction

    function void check_write(strip_write_t got);
      strip_write_t want;
      writes_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected strip write: led %0d color %08h last %0b",
                   got.led_index, got.packed_color, got.last_write);
        return;
      end
      want = pending.pop_front();
      if (got.led_index !== want.led_index || got.packed_color !== want.packed_color ||
          got.last_write !== want.last_write) begin
        errors++;
        if (errors <= 10)
          $display(
            "write %0d: expected led %0d color %08h last %0b, got led %0d color %08h last %0b",
            writes_seen, want.led_index, want.packed_color, want.last_write,
            got.led_index, got.packed_color, got.last_write);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic                  in_req_type = 1'b0;
  logic                  in_use_grid = 1'b0;
  logic [PIX_W-1:0]      in_pixel_index = '0;
  logic [GRID_W-1:0]     in_grid_col = '0;
  logic [GRID_W-1:0]     in_grid_row = '0;
  logic [BASE_W-1:0]     in_map_base = '0;
  logic [CHAN_W-1:0]     in_red_in = '0;
  logic [CHAN_W-1:0]     in_green_in = '0;
  logic [CHAN_W-1:0]     in_blue_in = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [LED_W-1:0]      out_led_index;
  logic [COLOR_W-1:0]    out_packed_color;
  logic                  out_last_write;

  strip_scoreboard sb = new();
  int  send_calm = 0;
  int  sink_calm = 0;
  int  settings_used = 0;
  int  full_cycles = 0;
  int  stall_cycles = 0;
  bit  squeeze_pending = 1'b0;

  led_pixel_fanout_writer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_req_type      (in_req_type),
    .in_use_grid      (in_use_grid),
    .in_pixel_index   (in_pixel_index),
    .in_grid_col      (in_grid_col),
    .in_grid_row      (in_grid_row),
    .in_map_base      (in_map_base),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_led_index    (out_led_index),
    .out_packed_color (out_packed_color),
    .out_last_write   (out_last_write)
  );

  always #10 clk = ~clk;

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (in_full) full_cycles++;
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle length per transfer, with occasional calm stretches of back-to-back traffic.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(5, 20);
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t make_req(logic kind, logic grid, int pix, int col, int row,
                                          int base, int r, int g, int b);
    pixel_req_t q;
    q.req_type    = kind;
    q.use_grid    = grid;
    q.pixel_index = PIX_W'(pix);
    q.grid_col    = GRID_W'(col);
    q.grid_row    = GRID_W'(row);
    q.map_base    = BASE_W'(base);
    q.red         = CHAN_W'(r);
    q.green       = CHAN_W'(g);
    q.blue        = CHAN_W'(b);
    return q;
  endfunction

  // Mostly writes to loaded pixels; unloaded targets turn into loads.
  function automatic pixel_req_t random_req();
    pixel_req_t q;
    int         slot;
    q.req_type    = ($urandom_range(0, 9) < 3) ? REQ_LOAD : REQ_WRITE;
    q.use_grid    = ($urandom_range(0, 3) == 0);
    q.pixel_index = ($urandom_range(0, 3) == 0) ?
                    PIX_W'($urandom_range(CORNER_START - 4, MAP_DEPTH - 1)) : PIX_W'($urandom);
    q.grid_col    = GRID_W'($urandom);
    q.grid_row    = GRID_W'($urandom);
    q.map_base    = BASE_W'($urandom);
    q.red         = pick_chan();
    q.green       = pick_chan();
    q.blue        = pick_chan();
    slot = strip_scoreboard::slot_of(q);
    if (q.req_type == REQ_WRITE && slot < MAP_DEPTH && !sb.loaded[slot]) q.req_type = REQ_LOAD;
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_req(input pixel_req_t q);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type    <= q.req_type;
    in_use_grid    <= q.use_grid;
    in_pixel_index <= q.pixel_index;
    in_grid_col    <= q.grid_col;
    in_grid_row    <= q.grid_row;
    in_map_base    <= q.map_base;
    in_red_in      <= q.red;
    in_green_in    <= q.green;
    in_blue_in     <= q.blue;
    in_push        <= 1'b1;
    do @(posedge clk); while (in_full);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic stop_and_drain();
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    // loads leave no result, so let the pipeline settle
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [3:0] l, input logic [3:0] c,
                              input logic [3:0] a, input logic [3:0] wm);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  regs [4];
    vals = '{l, c, a, wm};
    regs = '{CFG_LETTER_CNT, CFG_CORNER_CNT, CFG_ALARM_CNT, CFG_WHITE_MODE};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    sb.set_regs(l, c, a, wm[0]);
    settings_used++;
  endtask

  // Result side: random pops, plus one long hold-off to back up the input.
  initial begin
    int           gap;
    strip_write_t got;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_pop <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
      gap = draw_gap(sink_calm);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      got.led_index    = out_led_index;
      got.packed_color = out_packed_color;
      got.last_write   = out_last_write;
      sb.check_write(got);
      @(negedge clk);
    end
  end

  initial begin
    logic [3:0] l, c, a;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: group boundaries, map extremes, saturated run, grid addressing
    program_regs(4'd3, 4'd8, 4'd15, 4'b0110);
    push_req(make_req(REQ_LOAD, 0, 0, 0, 0, 8'h00, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 0, 127, 15, 15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_req(make_req(REQ_LOAD, 0, CORNER_START - 1, 0, 0, 200, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 0, CORNER_START, 0, 0, 100, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 0, ALARM_INDEX - 1, 0, 0, 17, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 0, ALARM_INDEX, 0, 0, 250, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 1, 0, 15, 15, 8'h55, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 1, 127, 7, 10, 8'hAA, 0, 0, 0));
    push_req(make_req(REQ_LOAD, 1, 127, 0, 0, 8'h0F, 0, 0, 0));
    push_req(make_req(REQ_WRITE, 0, 0, 15, 15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_req(make_req(REQ_WRITE, 0, 127, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    push_req(make_req(REQ_WRITE, 0, CORNER_START - 1, 0, 0, 0, 8'h12, 8'h34, 8'h56));
    push_req(make_req(REQ_WRITE, 0, CORNER_START, 0, 0, 0, 8'hFF, 8'h00, 8'h80));
    push_req(make_req(REQ_WRITE, 0, ALARM_INDEX - 1, 0, 0, 0, 8'h01, 8'hFE, 8'h7F));
    push_req(make_req(REQ_WRITE, 0, ALARM_INDEX, 0, 0, 0, 8'h80, 8'h80, 8'h80));
    push_req(make_req(REQ_WRITE, 1, 0, 15, 15, 0, 8'hAA, 8'h55, 8'hA5));
    push_req(make_req(REQ_WRITE, 1, 0, 7, 10, 0, 8'h3C, 8'hC3, 8'h99));
    stop_and_drain();

    // Directed: zero count, white extraction
    program_regs(4'd0, 4'd1, 4'd8, 4'b1011);
    push_req(make_req(REQ_WRITE, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    push_req(make_req(REQ_WRITE, 0, CORNER_START, 0, 0, 0, 8'h80, 8'h40, 8'hC0));
    push_req(make_req(REQ_WRITE, 0, 127, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    push_req(make_req(REQ_WRITE, 0, ALARM_INDEX, 0, 0, 0, 8'h00, 8'hFF, 8'h01));
    push_req(make_req(REQ_WRITE, 1, 0, 4, 10, 0, 8'hC8, 8'h64, 8'h96));
    stop_and_drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_regs(4'd1, 4'd1, 4'd1, 4'b0000);
        1: program_regs(4'd8, 4'd8, 4'd8, 4'b0001);
        2: program_regs(4'd15, 4'd0, 4'd4, {3'($urandom), 1'b0});
        default: begin
          l = 4'($urandom_range(0, 15));
          c = 4'($urandom_range(0, 15));
          a = 4'($urandom_range(0, 15));
          program_regs(l, c, a, 4'($urandom));
        end
      endcase
      // long runs in this phase; hold the result side to fill the job queue
      if (p == 1) squeeze_pending = 1'b1;
      repeat (PHASE_ITEMS) push_req(random_req());
      stop_and_drain();
    end

    repeat (20) @(negedge clk);
    $display("Sent %0d pixel requests (%0d map loads) over %0d register settings.",
             sb.requests, sb.loads, settings_used);
    $display("Checked %0d strip writes; input held off by a full queue for %0d cycles.",
             sb.writes_seen, full_cycles);
    if (sb.pending.size() != 0)
      $display("%0d strip writes never arrived", sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
